FILE: design/sli_pkg.sv
// Shared types and codes for the sorted list insert/delete block.
package sli_pkg;

	localparam int ENTRY_W = 8;
	localparam int COUNT_OUT_W = 5;
	localparam int IN_TDATA_W = 16;
	localparam int OUT_TDATA_W = 8;

	typedef logic signed [ENTRY_W-1:0] entry_t;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_DELETE = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_DELETED   = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_FULL      = 3'd3,
		ST_EMPTY     = 3'd4
	} status_t;

	// Broadcast from the control to every cell of the chain.
	typedef struct packed {
		logic   ins_en;
		logic   del_en;
		entry_t value;
	} cell_ctrl_t;

endpackage

FILE: design/sli_cell.sv
// One storage cell of the sorted chain: compare, then keep, load or shift.
module sli_cell (
	input  logic                clk,
	input  sli_pkg::cell_ctrl_t ctrl,
	input  logic                valid,
	input  logic                left_below,
	input  sli_pkg::entry_t     left_entry,
	input  sli_pkg::entry_t     right_entry,
	output logic                below,
	output logic                hit,
	output sli_pkg::entry_t     entry
);

	sli_pkg::entry_t entry_q;
	logic            ge;

	assign entry  = entry_q;
	// below: a valid entry strictly below the value stays in place on insert
	assign below  = valid && (ctrl.value > entry_q);
	assign hit    = valid && (entry_q == ctrl.value);
	assign ge     = !(ctrl.value > entry_q);

	always_ff @(posedge clk) begin
		priority if (ctrl.ins_en && !below) begin
			// load the new value at the insert point, shift right past it
			entry_q <= left_below ? ctrl.value : left_entry;
		end else if (ctrl.del_en && ge) begin
			// close the gap from the first match onward
			entry_q <= right_entry;
		end else begin
			entry_q <= entry_q;
		end
	end

endmodule

FILE: design/sorted_list_insert_delete.sv
// Top level of the sorted list insert/delete store: cell chain, count and result register.
// Results are registered and reach the master side in the cycle after the input transfer.
// One item per cycle unless m_axis stalls; all cells compare and shift at once.
// The output register frees the input side whenever the result is taken or absent.
// Reset clears the entry count and the output valid; stored entries are left as they are.
module sorted_list_insert_delete #(
	parameter int DEPTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// [0] cmd, [8:1] item_value, [15:9] zero
	input  logic [sli_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [2:0] status, [7:3] entry_count
	output logic [sli_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [CNT_W-1:0]        count_q;
	logic                    out_valid_q;
	sli_pkg::status_t        status_q;
	logic [CNT_W-1:0]        result_count_q;
	logic [CNT_W+4:0]        count_ext;

	sli_pkg::cmd_t           cmd;
	sli_pkg::entry_t         value;
	logic                    accept;
	logic                    full;
	logic                    empty;
	logic                    found;
	sli_pkg::cell_ctrl_t     ctrl;
	sli_pkg::status_t        status_d;
	logic [CNT_W-1:0]        count_d;

	logic [DEPTH-1:0]        valid;
	logic [DEPTH-1:0]        below;
	logic [DEPTH-1:0]        hit;
	sli_pkg::entry_t         entry [DEPTH];

	assign cmd    = sli_pkg::cmd_t'(s_axis_tdata[0]);
	assign value  = sli_pkg::entry_t'(s_axis_tdata[8:1]);
	assign accept = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = !out_valid_q || m_axis_tready;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign found = |hit;

	assign ctrl.ins_en = accept && (cmd == sli_pkg::CMD_INSERT) && !full;
	assign ctrl.del_en = accept && (cmd == sli_pkg::CMD_DELETE) && found;
	assign ctrl.value  = value;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign valid[i] = (CNT_W'(i) < count_q);

		sli_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.valid      (valid[i]),
			.left_below ((i == 0) ? 1'b1 : below[(i == 0) ? 0 : i - 1]),
			.left_entry (entry[(i == 0) ? 0 : i - 1]),
			.right_entry(entry[(i == DEPTH - 1) ? i : i + 1]),
			.below      (below[i]),
			.hit        (hit[i]),
			.entry      (entry[i])
		);
	end

	always_comb begin
		status_d = sli_pkg::ST_INSERTED;
		count_d  = count_q;
		unique case (cmd)
			sli_pkg::CMD_INSERT: begin
				if (full) begin
					status_d = sli_pkg::ST_FULL;
				end else begin
					status_d = sli_pkg::ST_INSERTED;
					count_d  = count_q + CNT_W'(1);
				end
			end
			sli_pkg::CMD_DELETE: begin
				priority if (empty) begin
					status_d = sli_pkg::ST_EMPTY;
				end else if (!found) begin
					status_d = sli_pkg::ST_NOT_FOUND;
				end else begin
					status_d = sli_pkg::ST_DELETED;
					count_d  = count_q - CNT_W'(1);
				end
			end
			default: begin
				status_d = sli_pkg::ST_INSERTED;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, held while the transfer stalls
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q       <= status_d;
			result_count_q <= count_d;
		end
	end

	assign count_ext     = {5'b0, result_count_q};
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {count_ext[sli_pkg::COUNT_OUT_W-1:0], status_q};

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (m_axis_tvalid && result_count_q == count_q))
		else $error("result count does not match stored count");

	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CNT_W'(2)) |-> (entry[0] <= entry[1]))
		else $error("head of list out of order");

	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && ctrl.ins_en) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("insert did not grow the list");

endmodule

FILE: verif/sorted_list_checker.sv
// Checker for the sorted list store: mirrors the list, predicts each result and compares it.
`timescale 1ns / 100ps

module sorted_list_checker
	import sli_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	// [0] cmd, [8:1] item_value, [15:9] zero
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	// [2:0] status, [7:3] entry_count
	input  logic [OUT_TDATA_W-1:0] m_tdata,
	output int                     fail_count,
	output int                     outstanding,
	output int                     results_checked,
	output int                     full_hits,
	output int                     empty_hits,
	output int                     miss_hits,
	output int                     peak_fill
);

	typedef struct packed {
		status_t                status;
		logic [COUNT_OUT_W-1:0] count;
	} list_result_t;

	entry_t       list_mem [DEPTH];
	int           list_len;
	list_result_t expected_results [$];
	list_result_t want;
	status_t      pred_status;

	task automatic report_mismatch(input string what, input int got, input int want_val);
		fail_count++;
		$display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want_val);
	endtask

	// Apply one insert or delete to the mirrored list and return its status.
	task automatic predict_list_op(input cmd_t op, input entry_t val, output status_t st);
		int pos;
		pos = 0;
		if (op == CMD_INSERT) begin
			if (list_len >= DEPTH) begin
				st = ST_FULL;
			end else begin
				// equal values go in front of the ones already stored
				while (pos < list_len && val > list_mem[pos])
					pos++;
				for (int i = list_len; i > pos; i--)
					list_mem[i] = list_mem[i-1];
				list_mem[pos] = val;
				list_len++;
				st = ST_INSERTED;
			end
		end else begin
			if (list_len == 0) begin
				st = ST_EMPTY;
			end else begin
				while (pos < list_len && list_mem[pos] != val)
					pos++;
				if (pos >= list_len) begin
					st = ST_NOT_FOUND;
				end else begin
					for (int i = pos; i + 1 < list_len; i++)
						list_mem[i] = list_mem[i+1];
					list_len--;
					st = ST_DELETED;
				end
			end
		end
	endtask

	initial begin
		fail_count      = 0;
		outstanding     = 0;
		results_checked = 0;
		full_hits       = 0;
		empty_hits      = 0;
		miss_hits       = 0;
		peak_fill       = 0;
		list_len        = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_len = 0;
			expected_results.delete();
			outstanding = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_list_op(cmd_t'(s_tdata[0]), entry_t'(s_tdata[ENTRY_W:1]), pred_status);
				case (pred_status)
					ST_FULL:      full_hits++;
					ST_EMPTY:     empty_hits++;
					ST_NOT_FOUND: miss_hits++;
					default:      ;
				endcase
				if (list_len > peak_fill)
					peak_fill = list_len;
				want.status = pred_status;
				want.count  = list_len[COUNT_OUT_W-1:0];
				expected_results.push_back(want);
			end
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result transfer", int'(m_tdata), -1);
				end else begin
					want = expected_results.pop_front();
					if (m_tdata[2:0] != want.status)
						report_mismatch("status", int'(m_tdata[2:0]), int'(want.status));
					if (m_tdata[7:3] != want.count)
						report_mismatch("entry_count", int'(m_tdata[7:3]), int'(want.count));
					results_checked++;
				end
			end
			outstanding = expected_results.size();
		end
	end

endmodule

FILE: verif/testbench.sv
// Top of the sorted list store testbench: clock, reset, stimulus, receiver and verdict.
`timescale 1ns / 100ps

module testbench;
	import sli_pkg::*;

	localparam int DEPTH       = 16;
	localparam int PHASES      = 11;
	localparam int PHASE_ITEMS = 98;
	localparam int HOLD_CYCLES = 300;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	bit tx_no_gap;
	bit rx_no_stall;
	bit rx_hold_req;
	int items_sent;

	int fail_count;
	int outstanding;
	int results_checked;
	int full_hits;
	int empty_hits;
	int miss_hits;
	int peak_fill;

	sorted_list_insert_delete #(
		.DEPTH(DEPTH)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	sorted_list_checker #(
		.DEPTH(DEPTH)
	) list_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_axis_tvalid),
		.s_tready       (s_axis_tready),
		.s_tdata        (s_axis_tdata),
		.m_tvalid       (m_axis_tvalid),
		.m_tready       (m_axis_tready),
		.m_tdata        (m_axis_tdata),
		.fail_count     (fail_count),
		.outstanding    (outstanding),
		.results_checked(results_checked),
		.full_hits      (full_hits),
		.empty_hits     (empty_hits),
		.miss_hits      (miss_hits),
		.peak_fill      (peak_fill)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Narrow values collide often, so deletes hit and duplicates pile up.
	function automatic entry_t draw_value(input bit narrow);
		if (!narrow)
			return entry_t'($urandom_range(0, 255));
		case ($urandom_range(0, 9))
			0:       return entry_t'(8'h80);
			1:       return entry_t'(8'h7F);
			default: return entry_t'(int'($urandom_range(0, 7)) - 4);
		endcase
	endfunction

	// Offer one item and hold it until the transfer; valid stays high for a back-to-back item.
	task automatic send_item(input cmd_t op, input entry_t val);
		int gap;
		gap = tx_no_gap ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(IN_TDATA_W-ENTRY_W-1){1'b0}}, val, op};
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
	endtask

	// Pause the sender until every pending result has been taken.
	task automatic wait_for_results();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		@(posedge clk);
	endtask

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		int stall;
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				stall = rx_no_stall ? 0 : $urandom_range(0, 10);
				if (stall > 0) begin
					m_axis_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	initial begin
		#5_000_000;
		$display("Timeout: run did not finish, %0d results still pending", outstanding);
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		int  ins_pct;
		bit  narrow;
		cmd_t op;
		tx_no_gap     = 1'b0;
		rx_no_stall   = 1'b0;
		rx_hold_req   = 1'b0;
		items_sent    = 0;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty delete, extremes, duplicates, miss, first-equal delete, full.
		send_item(CMD_DELETE, entry_t'(8'h00));
		send_item(CMD_INSERT, entry_t'(8'h7F));
		send_item(CMD_INSERT, entry_t'(8'h80));
		send_item(CMD_INSERT, entry_t'(8'h00));
		send_item(CMD_INSERT, entry_t'(8'h00));
		send_item(CMD_INSERT, entry_t'(8'hFF));
		send_item(CMD_DELETE, entry_t'(8'h05));
		send_item(CMD_DELETE, entry_t'(8'h00));
		send_item(CMD_DELETE, entry_t'(8'h80));
		send_item(CMD_DELETE, entry_t'(8'h7F));
		repeat (DEPTH - 2) send_item(CMD_INSERT, draw_value(1'b0));
		send_item(CMD_INSERT, entry_t'(8'h01));
		wait_for_results();

		// Random phases swing the fill level between empty and full.
		for (int p = 0; p < PHASES; p++) begin
			ins_pct     = (p % 3 == 0) ? 80 : (p % 3 == 1) ? 20 : 55;
			narrow      = (p % 4 != 3);
			tx_no_gap   = (p % 4 == 1) || (p == 4);
			rx_no_stall = (p % 3 == 2);
			if (p == 4)
				rx_hold_req = 1'b1;
			repeat (PHASE_ITEMS) begin
				op = ($urandom_range(1, 100) <= ins_pct) ? CMD_INSERT : CMD_DELETE;
				send_item(op, draw_value(narrow));
			end
			wait_for_results();
		end

		// Give a stray extra result time to show up.
		repeat (5) @(posedge clk);
		$display("Covered %0d items and %0d checked results, peak fill %0d of %0d",
			items_sent, results_checked, peak_fill, DEPTH);
		$display("Outcomes hit: %0d full inserts, %0d empty deletes, %0d delete misses",
			full_hits, empty_hits, miss_hits);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
